/* src/agw_pkg.sv */
package agw_pkg;

    localparam int KIND_W = 2;
    localparam int VERT_W = 5;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [VERT_W-1:0] vert_t;

    localparam kind_t KIND_ADD       = 2'd0;
    localparam kind_t KIND_REMOVE    = 2'd1;
    localparam kind_t KIND_WALK      = 2'd2;
    localparam kind_t KIND_TRANSPOSE = 2'd3;

endpackage

/* src/agw_if.sv */
interface agw_in_if import agw_pkg::*; ();
    logic  valid;
    logic  ready;
    kind_t kind;
    vert_t first_vertex;
    vert_t second_vertex;

    modport source (output valid, output kind, output first_vertex, output second_vertex,
                    input ready);
    modport sink (input valid, input kind, input first_vertex, input second_vertex,
                  output ready);
endinterface

interface agw_out_if import agw_pkg::*; ();
    logic  valid;
    logic  ready;
    vert_t vertex;
    logic  is_visit;
    logic  last;

    modport source (output valid, output vertex, output is_visit, output last,
                    input ready);
    modport sink (input valid, input vertex, input is_visit, input last,
                  output ready);
endinterface

/* src/agw_ram.sv */
module agw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/adjacency_matrix_graph_walk.sv */
// Channel  Direction  Payload                              Handshake
// req      in         kind, first_vertex, second_vertex    valid/ready
// rsp      out        vertex, is_visit, last               valid/ready
//
// After reset a clearing pass writes zero to every matrix row, during which req.ready
// stays low. Add edge reads two rows and writes them back with the edge bits set,
// transpose toggles the row flip, remove vertex clears its row and column in one
// row sweep. One item at a time: a walk pushes the start vertex on a serial stack,
// and for each popped vertex reads its row, pushes its unvisited neighbors, emits it.
// A stalled rsp holds the walk; req is taken again once the final result is loaded.
module adjacency_matrix_graph_walk import agw_pkg::*; #(
    parameter int NODES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    agw_in_if.sink    req,
    agw_out_if.source rsp
);

    localparam int VW = $clog2(NODES);
    localparam int DW = VW + 1;
    localparam int CW = ((VERT_W > DW) ? VERT_W : DW) + 1;

    localparam logic [CW-1:0]    NODES_C    = CW'(NODES);
    localparam logic [DW-1:0]    DEPTH_FULL = DW'(NODES);
    localparam logic [NODES-1:0] BIT0       = NODES'(1);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ADD  = 4'd2;
    localparam logic [3:0] S_CLR  = 4'd3;
    localparam logic [3:0] S_ACK  = 4'd4;
    localparam logic [3:0] S_POP  = 4'd5;
    localparam logic [3:0] S_WRD  = 4'd6;
    localparam logic [3:0] S_LOAD = 4'd7;
    localparam logic [3:0] S_SCAN = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic             flip_reg, flip_next;
    logic [VW-1:0]    a_reg, a_next;
    logic [VW-1:0]    b_reg, b_next;
    logic [DW-1:0]    sweep_reg, sweep_next;
    logic             pend_reg, pend_next;
    logic [VW-1:0]    pend_idx_reg, pend_idx_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [VW-1:0]    cur_reg, cur_next;
    logic [NODES-1:0] visited_reg, visited_next;
    logic [NODES-1:0] cand_reg, cand_next;
    logic             out_valid_reg, out_valid_next;
    vert_t            out_vertex_reg, out_vertex_next;
    logic             out_visit_reg, out_visit_next;
    logic             out_last_reg, out_last_next;

    logic             mat_re, mat_we;
    logic [VW-1:0]    raddr0, raddr1, waddr0, waddr1;
    logic [NODES-1:0] wdata0, wdata1, q0, q1, row_a;

    logic             stk_we, stk_re;
    logic [VW-1:0]    stk_waddr, stk_raddr, stk_wdata, stk_q;

    logic [VW-1:0]    fv, sv;
    logic             fv_ok, sv_ok, slot_free;
    logic             load_ack, load_visit;
    logic [VW-1:0]    low_idx;
    logic [NODES-1:0] low_bit;
    logic [DW-1:0]    depth_dec;

    agw_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_mat0 (
        .clk   (clk),
        .we    (mat_we),
        .waddr (waddr0),
        .wdata (wdata0),
        .re    (mat_re),
        .raddr (raddr0),
        .rdata (q0)
    );

    agw_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_mat1 (
        .clk   (clk),
        .we    (mat_we),
        .waddr (waddr1),
        .wdata (wdata1),
        .re    (mat_re),
        .raddr (raddr1),
        .rdata (q1)
    );

    agw_ram #(.WIDTH(VW), .DEPTH(NODES)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    assign fv        = VW'(req.first_vertex);
    assign sv        = VW'(req.second_vertex);
    assign fv_ok     = CW'(req.first_vertex) < NODES_C;
    assign sv_ok     = CW'(req.second_vertex) < NODES_C;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign row_a     = flip_reg ? q1 : q0;
    assign low_bit   = cand_reg & (~cand_reg + BIT0);
    assign depth_dec = depth_reg - DW'(1);

    always_comb
    begin
        low_idx = '0;
        for (int k = NODES - 1; k >= 0; k--)
        begin
            if (cand_reg[k])
            begin
                low_idx = VW'(k);
            end
        end
    end

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        flip_next     = flip_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        sweep_next    = sweep_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        depth_next    = depth_reg;
        cur_next      = cur_reg;
        visited_next  = visited_reg;
        cand_next     = cand_reg;
        mat_re        = 1'b0;
        mat_we        = 1'b0;
        raddr0        = '0;
        raddr1        = '0;
        waddr0        = '0;
        waddr1        = '0;
        wdata0        = '0;
        wdata1        = '0;
        stk_we        = 1'b0;
        stk_re        = 1'b0;
        stk_waddr     = '0;
        stk_raddr     = '0;
        stk_wdata     = '0;
        load_ack      = 1'b0;
        load_visit    = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                if (sweep_reg != DEPTH_FULL)
                begin
                    mat_we     = 1'b1;
                    waddr0     = sweep_reg[VW-1:0];
                    waddr1     = sweep_reg[VW-1:0];
                    sweep_next = sweep_reg + DW'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.kind)
                        KIND_ADD:
                        begin
                            if (fv_ok && sv_ok)
                            begin
                                mat_re     = 1'b1;
                                raddr0     = flip_reg ? sv : fv;
                                raddr1     = flip_reg ? fv : sv;
                                a_next     = fv;
                                b_next     = sv;
                                state_next = S_ADD;
                            end
                            else
                            begin
                                state_next = S_ACK;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (fv_ok)
                            begin
                                a_next     = fv;
                                sweep_next = '0;
                                pend_next  = 1'b0;
                                state_next = S_CLR;
                            end
                            else
                            begin
                                state_next = S_ACK;
                            end
                        end
                        KIND_WALK:
                        begin
                            if (fv_ok)
                            begin
                                stk_we       = 1'b1;
                                stk_waddr    = '0;
                                stk_wdata    = fv;
                                depth_next   = DW'(1);
                                visited_next = BIT0 << fv;
                                state_next   = S_POP;
                            end
                            else
                            begin
                                state_next = S_ACK;
                            end
                        end
                        default:
                        begin
                            flip_next  = !flip_reg;
                            state_next = S_ACK;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                mat_we     = 1'b1;
                waddr0     = flip_reg ? b_reg : a_reg;
                wdata0     = q0 | (BIT0 << (flip_reg ? a_reg : b_reg));
                waddr1     = flip_reg ? a_reg : b_reg;
                wdata1     = q1 | (BIT0 << (flip_reg ? b_reg : a_reg));
                state_next = S_ACK;
            end
            S_CLR:
            begin
                if (sweep_reg != DEPTH_FULL)
                begin
                    mat_re     = 1'b1;
                    raddr0     = sweep_reg[VW-1:0];
                    raddr1     = sweep_reg[VW-1:0];
                    sweep_next = sweep_reg + DW'(1);
                end
                pend_next     = (sweep_reg != DEPTH_FULL);
                pend_idx_next = sweep_reg[VW-1:0];
                if (pend_reg)
                begin
                    mat_we = 1'b1;
                    waddr0 = pend_idx_reg;
                    waddr1 = pend_idx_reg;
                    wdata0 = (pend_idx_reg == a_reg) ? '0 : (q0 & ~(BIT0 << a_reg));
                    wdata1 = (pend_idx_reg == a_reg) ? '0 : (q1 & ~(BIT0 << a_reg));
                end
                if (!pend_reg && (sweep_reg == DEPTH_FULL))
                begin
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (slot_free)
                begin
                    load_ack   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                stk_re     = 1'b1;
                stk_raddr  = depth_dec[VW-1:0];
                depth_next = depth_dec;
                state_next = S_WRD;
            end
            S_WRD:
            begin
                cur_next   = stk_q;
                mat_re     = 1'b1;
                raddr0     = stk_q;
                raddr1     = stk_q;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cand_next  = row_a & ~visited_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cand_reg != '0)
                begin
                    stk_we       = 1'b1;
                    stk_waddr    = depth_reg[VW-1:0];
                    stk_wdata    = low_idx;
                    depth_next   = depth_reg + DW'(1);
                    visited_next = visited_reg | low_bit;
                    cand_next    = cand_reg & ~low_bit;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    load_visit = 1'b1;
                    state_next = (depth_reg == '0) ? S_IDLE : S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vertex_next = out_vertex_reg;
        out_visit_next  = out_visit_reg;
        out_last_next   = out_last_reg;
        if (load_ack)
        begin
            out_vertex_next = '0;
            out_visit_next  = 1'b0;
            out_last_next   = 1'b1;
        end
        else if (load_visit)
        begin
            out_vertex_next = VERT_W'(cur_reg);
            out_visit_next  = 1'b1;
            out_last_next   = (depth_reg == '0);
        end

        if (load_ack || load_visit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            flip_reg      <= 1'b0;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            depth_reg     <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flip_reg      <= flip_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        pend_idx_reg   <= pend_idx_next;
        cur_reg        <= cur_next;
        cand_reg       <= cand_next;
        out_vertex_reg <= out_vertex_next;
        out_visit_reg  <= out_visit_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.vertex   = out_vertex_reg;
    assign rsp.is_visit = out_visit_reg;
    assign rsp.last     = out_last_reg;

endmodule

/* src/agw_check.sv */
module agw_check import agw_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_ready,
    input logic  rsp_valid,
    input logic  rsp_ready,
    input vert_t rsp_vertex,
    input logic  rsp_is_visit,
    input logic  rsp_last
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("A stalled result item was dropped.");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_vertex) && $stable(rsp_is_visit) && $stable(rsp_last))
        else $error("A stalled result item changed.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("A request item was taken while the previous one was still at work.");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_visit && !rsp_last |-> !req_ready)
        else $error("A request item was offered ready in the middle of a walk.");

    a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_is_visit |-> rsp_last && (rsp_vertex == '0))
        else $error("An acknowledge item is not a single final item with vertex zero.");

endmodule

bind adjacency_matrix_graph_walk agw_check u_agw_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_vertex   (rsp.vertex),
    .rsp_is_visit (rsp.is_visit),
    .rsp_last     (rsp.last)
);
